[rtl/paged_segment_allocator_macros.svh]
// Assertion macros for the allocator RTL.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef PAGED_SEGMENT_ALLOCATOR_MACROS_SVH
`define PAGED_SEGMENT_ALLOCATOR_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define PSA_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define PSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/psa_pkg.sv]
// Package for the paged segment allocator: beat types, codes and defaults.
// No dependencies; the divider and the allocator import it.
`timescale 1ns / 1ps

package psa_pkg;

	// Block and page sizes must be powers of two; offsets are split by shift and mask.
	localparam int DEF_NUM_PAGES      = 16;
	localparam int DEF_SLOTS_PER_PAGE = 64;
	localparam int DEF_BLOCK_BYTES    = 32;
	localparam int DEF_PAGE_BYTES     = 2048;

	localparam int DATA_W  = 32;
	localparam int SHIFT_W = $clog2(DATA_W);
	localparam int ENT_W   = 8;
	localparam int OWNER_W = 17;
	localparam int LIMIT_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [OWNER_W-1:0] UNOWNED = 17'h10000;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_BADSIZE = 2'd2;
	localparam logic [1:0] ST_BADADDR = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] request_bytes;
		logic [31:0] address;
		logic [15:0] requester_id;
	} psa_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_address;
		logic [3:0]  page_number;
		logic        page_made_present;
		logic        page_released;
	} psa_rsp_t;

endpackage

[rtl/psa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module psa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/psa_div.sv]
// Shared shift-and-mask unit: divides by a power of two, with a registered quotient and remainder.
// Depends on psa_pkg for the data and shift widths.
`timescale 1ns / 1ps

module psa_div
	import psa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DATA_W-1:0]  dividend,
	input  logic [SHIFT_W-1:0] shift,
	output logic               done,
	output logic [DATA_W-1:0]  quotient,
	output logic [DATA_W-1:0]  remainder
);

	logic              done_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend >> shift;
			rem_q <= dividend & ~({DATA_W{1'b1}} << shift);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[rtl/paged_segment_allocator.sv]
// Paged segment allocator. One beat at a time: an allocate takes one shift step, then a
// scan per open page tried (a page skipped on free run or owner is not scanned), possibly a
// pass to open a gap and a free-run refresh, or else the clearing of a freshly opened page.
// A release takes two shift steps and up to five passes over the page row.
// The segment RAM port (one read, one write per cycle) sets the per-slot pace.
// Reset clears control state, owners and free-run figures; a page's row is cleared on open.
`timescale 1ns / 1ps
`include "paged_segment_allocator_macros.svh"

module paged_segment_allocator
	import psa_pkg::*;
#(
	parameter int NUM_PAGES      = DEF_NUM_PAGES,
	parameter int SLOTS_PER_PAGE = DEF_SLOTS_PER_PAGE,
	parameter int BLOCK_BYTES    = DEF_BLOCK_BYTES,
	parameter int PAGE_BYTES     = DEF_PAGE_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  psa_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output psa_rsp_t             rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	// Widths that follow from the geometry.
	localparam int SW    = $clog2(SLOTS_PER_PAGE + 1);
	localparam int ACW   = SW + 1;
	localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int POW   = $clog2(NUM_PAGES + 1);
	localparam int DEPTH = NUM_PAGES * SLOTS_PER_PAGE;
	localparam int AW    = $clog2(DEPTH);
	localparam int BLK_SH = $clog2(BLOCK_BYTES);
	localparam int PG_SH  = $clog2(PAGE_BYTES);

	localparam logic [SW-1:0] SLOTS_V = SW'(SLOTS_PER_PAGE);
	localparam logic [SW-1:0] LAST    = SW'(SLOTS_PER_PAGE - 1);

	// Sequencer states.
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DIV1  = 5'd1;
	localparam logic [4:0] S_DIV2  = 5'd2;
	localparam logic [4:0] S_APAGE = 5'd3;
	localparam logic [4:0] S_ASCAN = 5'd4;
	localparam logic [4:0] S_ASHR  = 5'd5;
	localparam logic [4:0] S_AWK1  = 5'd6;
	localparam logic [4:0] S_AWK0  = 5'd7;
	localparam logic [4:0] S_CLEAR = 5'd8;
	localparam logic [4:0] S_RSCAN = 5'd9;
	localparam logic [4:0] S_RWR   = 5'd10;
	localparam logic [4:0] S_RSHL  = 5'd11;
	localparam logic [4:0] S_TSCAN = 5'd12;
	localparam logic [4:0] S_TZERO = 5'd13;
	localparam logic [4:0] S_RUN   = 5'd14;
	localparam logic [4:0] S_ADDR  = 5'd15;
	localparam logic [4:0] S_OUT   = 5'd16;

	logic [4:0]          state_q;
	psa_req_t            req_q;
	psa_rsp_t            res_q;
	psa_rsp_t            rsp_q;
	logic                rsp_valid_q;
	logic [DATA_W-1:0]   base_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [POW-1:0]      pages_open_q;
	logic [SW-1:0]       lfr_q [NUM_PAGES];
	logic [OWNER_W-1:0]  owner_q [NUM_PAGES];

	logic [SW-1:0]       blk_q;
	logic [POW-1:0]      page_q;
	logic [AW-1:0]       row_q;
	logic [DATA_W-1:0]   b_q;
	logic [SW-1:0]       cnt_q;
	logic                init_q;
	logic                fin_q;

	// Scan bookkeeping, shared between the passes.
	logic [ACW-1:0]      acc_q;
	logic                stop_q;
	logic                hit_found_q;
	logic                hit_exact_q;
	logic [SW-1:0]       hit_idx_q;
	logic [ACW-1:0]      hit_sum_q;
	logic                k_found_q;
	logic [SW-1:0]       k_idx_q;
	logic [ACW-1:0]      k_sum_q;
	logic signed [7:0]   kval_q;
	logic signed [7:0]   lastv_q;
	logic signed [7:0]   pv_q;
	logic signed [7:0]   nxt_q;
	logic signed [7:0]   best_q;
	logic                inrun_q;
	logic [SW-1:0]       runstart_q;
	logic [SW-1:0]       rs_last_q;
	logic                nz_q;
	logic [ACW-1:0]      pos_sum_q;

	// Single writes and shift passes.
	logic [SW-1:0]       wr_idx_q;
	logic [ENT_W-1:0]    wr_val_q;
	logic [1:0]          d_q;
	logic                wr_pend_s1;
	logic [SW-1:0]       wr_addr_s1;
	logic                wr_zero_s1;

	// Memory and divider connections.
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ENT_W-1:0]    ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [ENT_W-1:0]    ram_rdata;
	logic                div_start;
	logic [DATA_W-1:0]   div_dividend;
	logic [SHIFT_W-1:0]  div_shift;
	logic                div_done;
	logic [DATA_W-1:0]   div_quo;
	logic [DATA_W-1:0]   div_rem;

	logic                accept;
	logic                bad_size;
	logic [PW-1:0]       pi;
	logic signed [7:0]   v;
	logic [7:0]          mag;
	logic [SW-1:0]       idx;
	logic signed [7:0]   blk_s;
	logic                pm;
	logic                nm;
	logic signed [7:0]   rel_val;
	logic [SW-1:0]       rel_t;
	logic [1:0]          rel_d;
	logic [SW-1:0]       e_idx;
	logic [SW-1:0]       rs_now;
	logic signed [9:0]   room_w;
	logic signed [9:0]   best_w;
	logic [SW-1:0]       lfr_new;
	logic [SW:0]         shl_src;
	logic                page_fits;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// An allocate of zero bytes or above one page is rejected before any work.
	assign bad_size = (req.action == ACT_ALLOC) &&
		((req.request_bytes == '0) || (req.request_bytes > DATA_W'(PAGE_BYTES)));

	assign pi    = page_q[PW-1:0];
	assign v     = signed'(ram_rdata);
	assign mag   = v[7] ? 8'(-v) : 8'(v);
	assign idx   = cnt_q - SW'(1);
	assign blk_s = signed'(8'(blk_q));

	// Release merge: fold a free right neighbor and a free left neighbor into the
	// freed segment, then drop the entries that were absorbed.
	assign pm      = (k_idx_q != '0) && (pv_q > 0);
	assign nm      = (k_idx_q != LAST) && (nxt_q > 0);
	assign rel_val = 8'(-kval_q) + (nm ? nxt_q : 8'sd0) + (pm ? pv_q : 8'sd0);
	assign rel_t   = pm ? (k_idx_q - SW'(1)) : k_idx_q;
	assign rel_d   = {1'b0, pm} + {1'b0, nm};

	// End of the live list for a split; a full list drops its last entry.
	assign e_idx = hit_found_q ? hit_idx_q : LAST;

	assign rs_now  = inrun_q ? runstart_q : idx;
	assign room_w  = 10'(SLOTS_PER_PAGE) - 10'(acc_q);
	assign best_w  = 10'(best_q);
	assign lfr_new = (room_w > best_w) ? SW'(room_w) : SW'(best_w);
	assign shl_src = {1'b0, cnt_q} + (SW+1)'(d_q);

	assign page_fits = (lfr_q[pi] >= blk_q) &&
		((owner_q[pi] == UNOWNED) || (owner_q[pi] == {1'b0, req_q.requester_id}));

	// The shift unit serves three quotients: blocks per request, page of an address,
	// and block offset within the page.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = div_rem;
		div_shift    = SHIFT_W'(BLK_SH);
		if (state_q == S_IDLE) begin
			div_start = accept && !bad_size;
			if (req.action == ACT_FREE) begin
				div_dividend = req.address - base_q;
				div_shift    = SHIFT_W'(PG_SH);
			end else begin
				div_dividend = req.request_bytes + DATA_W'(BLOCK_BYTES - 1);
			end
		end else if (state_q == S_DIV1) begin
			div_start = div_done && (req_q.action == ACT_FREE) &&
				(div_quo < DATA_W'(pages_open_q));
		end
	end

	// Segment RAM port steering.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = row_q + AW'(wr_idx_q);
		ram_wdata = wr_val_q;
		ram_raddr = row_q + AW'(cnt_q);
		case (state_q)
			S_ASHR, S_RSHL: begin
				ram_we    = wr_pend_s1;
				ram_waddr = row_q + AW'(wr_addr_s1);
				ram_wdata = wr_zero_s1 ? '0 : ram_rdata;
				ram_raddr = (state_q == S_ASHR) ? row_q + AW'(cnt_q - SW'(1))
					: row_q + AW'(shl_src);
			end
			S_AWK1: begin
				ram_we    = 1'b1;
				ram_waddr = row_q + AW'(k_idx_q) + AW'(1);
				ram_wdata = 8'(kval_q - blk_s);
			end
			S_AWK0, S_RWR: begin
				ram_we = 1'b1;
			end
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = row_q + AW'(cnt_q);
				ram_wdata = (cnt_q == '0) ? 8'(-blk_s) : '0;
			end
			S_TZERO: begin
				ram_we    = 1'b1;
				ram_waddr = row_q + AW'(cnt_q);
				ram_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	psa_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_seg_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	psa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.shift    (div_shift),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			res_q        <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
			base_q       <= '0;
			limit_q      <= LIMIT_W'(16);
			pages_open_q <= '0;
			for (int p = 0; p < NUM_PAGES; p++) begin
				lfr_q[p]   <= SLOTS_V;
				owner_q[p] <= UNOWNED;
			end
			blk_q       <= '0;
			page_q      <= '0;
			row_q       <= '0;
			b_q         <= '0;
			cnt_q       <= '0;
			init_q      <= 1'b0;
			fin_q       <= 1'b0;
			acc_q       <= '0;
			stop_q      <= 1'b0;
			hit_found_q <= 1'b0;
			hit_exact_q <= 1'b0;
			hit_idx_q   <= '0;
			hit_sum_q   <= '0;
			k_found_q   <= 1'b0;
			k_idx_q     <= '0;
			k_sum_q     <= '0;
			kval_q      <= '0;
			lastv_q     <= '0;
			pv_q        <= '0;
			nxt_q       <= '0;
			best_q      <= '0;
			inrun_q     <= 1'b0;
			runstart_q  <= '0;
			rs_last_q   <= '0;
			nz_q        <= 1'b0;
			pos_sum_q   <= '0;
			wr_idx_q    <= '0;
			wr_val_q    <= '0;
			d_q         <= '0;
			wr_pend_s1  <= 1'b0;
			wr_addr_s1  <= '0;
			wr_zero_s1  <= 1'b0;
		end else begin
			// The output stage reloads the register itself when it hands over a beat.
			if (rsp_valid_q && !rsp_stall && (state_q != S_OUT)) begin
				rsp_valid_q <= 1'b0;
			end

			// The user must send configuration writes only while idle; the block does not enforce it.
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BASE:  base_q  <= cfg_data;
					REG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				endcase
			end

			// Every scan of a page row starts from clean bookkeeping.
			if (init_q) begin
				init_q      <= 1'b0;
				cnt_q       <= '0;
				fin_q       <= 1'b0;
				acc_q       <= '0;
				stop_q      <= 1'b0;
				hit_found_q <= 1'b0;
				hit_exact_q <= 1'b0;
				k_found_q   <= 1'b0;
				lastv_q     <= '0;
				nxt_q       <= '0;
				best_q      <= '0;
				inrun_q     <= 1'b0;
				nz_q        <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q                   <= req;
						res_q.status            <= bad_size ? ST_BADSIZE : ST_OK;
						res_q.result_address    <= '0;
						res_q.page_number       <= '0;
						res_q.page_made_present <= 1'b0;
						res_q.page_released     <= 1'b0;
						if (bad_size) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV1;
						end
					end
				end

				S_DIV1: begin
					if (div_done) begin
						if (req_q.action == ACT_ALLOC) begin
							if (div_quo > DATA_W'(SLOTS_PER_PAGE)) begin
								res_q.status <= ST_NOMEM;
								state_q      <= S_OUT;
							end else begin
								blk_q   <= div_quo[SW-1:0];
								page_q  <= '0;
								state_q <= S_APAGE;
							end
						end else if (div_quo < DATA_W'(pages_open_q)) begin
							page_q            <= div_quo[POW-1:0];
							row_q             <= AW'(div_quo[PW-1:0] * SLOTS_PER_PAGE);
							res_q.page_number <= 4'(div_quo[PW-1:0]);
							state_q           <= S_DIV2;
						end else begin
							res_q.status <= ST_BADADDR;
							state_q      <= S_OUT;
						end
					end
				end

				S_DIV2: begin
					if (div_done) begin
						if (div_rem != '0) begin
							res_q.status <= ST_BADADDR;
							state_q      <= S_OUT;
						end else begin
							b_q     <= div_quo;
							init_q  <= 1'b1;
							state_q <= S_RSCAN;
						end
					end
				end

				// Walk open pages in order; open a fresh one when none fits and the page limit allows.
				S_APAGE: begin
					row_q <= AW'(32'(pi) * SLOTS_PER_PAGE);
					if (page_q < pages_open_q) begin
						if (page_fits) begin
							init_q  <= 1'b1;
							state_q <= S_ASCAN;
						end else begin
							page_q <= page_q + POW'(1);
						end
					end else if ((32'(pages_open_q) < 32'(limit_q)) &&
						(32'(pages_open_q) < NUM_PAGES)) begin
						cnt_q   <= '0;
						state_q <= S_CLEAR;
					end else begin
						res_q.status <= ST_NOMEM;
						state_q      <= S_OUT;
					end
				end

				S_ASCAN: begin
					if (!init_q) begin
						if (fin_q) begin
							wr_val_q <= 8'(-blk_s);
							if (hit_found_q && hit_exact_q) begin
								wr_idx_q  <= hit_idx_q;
								pos_sum_q <= hit_sum_q;
								state_q   <= S_AWK0;
							end else if (k_found_q) begin
								wr_idx_q  <= k_idx_q;
								pos_sum_q <= k_sum_q;
								if (k_idx_q == LAST) begin
									state_q <= S_AWK0;
								end else if ({1'b0, e_idx} > ({1'b0, k_idx_q} + (SW+1)'(1))) begin
									cnt_q      <= e_idx;
									wr_pend_s1 <= 1'b0;
									state_q    <= S_ASHR;
								end else begin
									state_q <= S_AWK1;
								end
							end else if (hit_found_q) begin
								wr_idx_q  <= hit_idx_q;
								pos_sum_q <= hit_sum_q;
								state_q   <= S_AWK0;
							end else begin
								page_q  <= page_q + POW'(1);
								state_q <= S_APAGE;
							end
						end else begin
							if (cnt_q != '0 && !stop_q) begin
								if (v == 8'sd0 || v == blk_s) begin
									hit_found_q <= 1'b1;
									hit_exact_q <= (v != 8'sd0);
									hit_idx_q   <= idx;
									hit_sum_q   <= acc_q;
									stop_q      <= 1'b1;
								end else begin
									if (v >= blk_s && (!k_found_q || v < kval_q)) begin
										k_found_q <= 1'b1;
										k_idx_q   <= idx;
										k_sum_q   <= acc_q;
										kval_q    <= v;
									end
									acc_q <= acc_q + ACW'(mag);
								end
							end
							if (cnt_q == SLOTS_V) begin
								fin_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + SW'(1);
							end
						end
					end
				end

				// Open a gap after the split segment, moving entries up by one.
				S_ASHR: begin
					wr_zero_s1 <= 1'b0;
					if ({1'b0, cnt_q} > ({1'b0, k_idx_q} + (SW+1)'(1))) begin
						wr_pend_s1 <= 1'b1;
						wr_addr_s1 <= cnt_q;
						cnt_q      <= cnt_q - SW'(1);
					end else begin
						wr_pend_s1 <= 1'b0;
						if (!wr_pend_s1) begin
							state_q <= S_AWK1;
						end
					end
				end

				S_AWK1: begin
					state_q <= S_AWK0;
				end

				S_AWK0: begin
					init_q  <= 1'b1;
					state_q <= S_RUN;
				end

				S_CLEAR: begin
					if (cnt_q == LAST) begin
						lfr_q[pi]    <= SLOTS_V - blk_q;
						owner_q[pi]  <= {1'b0, req_q.requester_id};
						pages_open_q <= pages_open_q + POW'(1);
						pos_sum_q    <= '0;
						state_q      <= S_ADDR;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end

				// Find the used segment that starts at the released block offset.
				S_RSCAN: begin
					if (!init_q) begin
						if (fin_q) begin
							if (!k_found_q || kval_q >= 0) begin
								res_q.status <= ST_BADADDR;
								state_q      <= S_OUT;
							end else begin
								wr_idx_q <= rel_t;
								wr_val_q <= 8'(rel_val);
								d_q      <= rel_d;
								state_q  <= S_RWR;
							end
						end else begin
							if (cnt_q != '0) begin
								lastv_q <= v;
								if (k_found_q && ({1'b0, idx} == ({1'b0, k_idx_q} + (SW+1)'(1)))) begin
									nxt_q <= v;
								end
								if (!stop_q) begin
									if (v == 8'sd0) begin
										stop_q <= 1'b1;
									end else if (32'(acc_q) == b_q) begin
										k_found_q <= 1'b1;
										k_idx_q   <= idx;
										kval_q    <= v;
										pv_q      <= lastv_q;
										stop_q    <= 1'b1;
									end else begin
										acc_q <= acc_q + ACW'(mag);
										if (32'(acc_q) + 32'(mag) > b_q) begin
											stop_q <= 1'b1;
										end
									end
								end
							end
							if (cnt_q == SLOTS_V) begin
								fin_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + SW'(1);
							end
						end
					end
				end

				S_RWR: begin
					if (d_q == '0) begin
						init_q  <= 1'b1;
						state_q <= S_TSCAN;
					end else begin
						cnt_q      <= wr_idx_q + SW'(1);
						wr_pend_s1 <= 1'b0;
						state_q    <= S_RSHL;
					end
				end

				// Close the gap left by absorbed neighbors, zero filling the tail.
				S_RSHL: begin
					if (cnt_q < SLOTS_V) begin
						wr_pend_s1 <= 1'b1;
						wr_addr_s1 <= cnt_q;
						wr_zero_s1 <= (shl_src >= {1'b0, SLOTS_V});
						cnt_q      <= cnt_q + SW'(1);
					end else begin
						wr_pend_s1 <= 1'b0;
						if (!wr_pend_s1) begin
							init_q  <= 1'b1;
							state_q <= S_TSCAN;
						end
					end
				end

				// Locate the run of free entries that ends the list.
				S_TSCAN: begin
					if (!init_q) begin
						if (fin_q) begin
							if (nz_q && rs_last_q < SLOTS_V) begin
								cnt_q   <= rs_last_q;
								state_q <= S_TZERO;
							end else begin
								init_q  <= 1'b1;
								state_q <= S_RUN;
							end
						end else begin
							if (cnt_q != '0) begin
								if (v > 8'sd0) begin
									inrun_q    <= 1'b1;
									runstart_q <= rs_now;
								end else begin
									inrun_q <= 1'b0;
								end
								if (v != 8'sd0) begin
									nz_q      <= 1'b1;
									rs_last_q <= (v > 8'sd0) ? rs_now : cnt_q;
								end
							end
							if (cnt_q == SLOTS_V) begin
								fin_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + SW'(1);
							end
						end
					end
				end

				S_TZERO: begin
					if (cnt_q == LAST) begin
						init_q  <= 1'b1;
						state_q <= S_RUN;
					end else begin
						cnt_q <= cnt_q + SW'(1);
					end
				end

				// Refresh the page's largest free run: best free segment or tail room.
				S_RUN: begin
					if (!init_q) begin
						if (fin_q) begin
							lfr_q[pi] <= lfr_new;
							if (req_q.action == ACT_ALLOC) begin
								owner_q[pi] <= {1'b0, req_q.requester_id};
								state_q     <= S_ADDR;
							end else begin
								res_q.status <= ST_OK;
								if (lfr_new == SLOTS_V) begin
									owner_q[pi]         <= UNOWNED;
									res_q.page_released <= 1'b1;
								end
								state_q <= S_OUT;
							end
						end else begin
							if (cnt_q != '0 && !stop_q) begin
								if (v == 8'sd0) begin
									stop_q <= 1'b1;
								end else begin
									acc_q <= acc_q + ACW'(mag);
									if (v > best_q) begin
										best_q <= v;
									end
								end
							end
							if (cnt_q == SLOTS_V) begin
								fin_q <= 1'b1;
							end else begin
								cnt_q <= cnt_q + SW'(1);
							end
						end
					end
				end

				S_ADDR: begin
					res_q.status            <= ST_OK;
					res_q.page_made_present <= 1'b1;
					res_q.page_number       <= 4'(pi);
					res_q.result_address    <= base_q + 32'(32'(pi) * PAGE_BYTES) +
						32'(32'(pos_sum_q) * BLOCK_BYTES);
					state_q <= S_OUT;
				end

				// Hand the result to the output register once it is free.
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`PSA_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted beat left the sequencer idle")
	`PSA_ASSERT_NOW(a_pages_bound, 32'(pages_open_q) <= NUM_PAGES, "more pages open than exist")
	`PSA_ASSERT_IMP(a_present_ok, rsp_valid && rsp.page_made_present, rsp.status == ST_OK && !rsp.page_released, "inconsistent allocate result")
	`PSA_ASSERT_IMP(a_div_start, div_start, state_q == S_IDLE || state_q == S_DIV1, "divider started outside a division step")
	`PSA_ASSERT_NOW(a_pow2_geom, ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0) && ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0), "block and page sizes must be powers of two")

endmodule
